[rtl/core/jsu_pkg.sv]
// Shared types and constants for the JSON string unescape block.
// Used by jsu_decode and json_string_unescape; depends on nothing.
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_QMARK     = 8'h3F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;
  localparam logic [7:0] CODE_BS      = 8'h08;
  localparam logic [7:0] CODE_FF      = 8'h0C;
  localparam logic [7:0] CODE_LF      = 8'h0A;
  localparam logic [7:0] CODE_CR      = 8'h0D;
  localparam logic [7:0] CODE_TAB     = 8'h09;
  localparam logic [15:0] ASCII_MAX   = 16'h007F;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  // Results caused by one input beat, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_t;

endpackage

[rtl/core/json_string_unescape.sv]
// Streaming JSON string literal unescaper: one raw byte in per beat.
// Each result is registered into the result queue when its byte is accepted.
// One byte is accepted per cycle while data_stall is low; a byte giving two results queues both.
// The four-entry result queue stalls input when fewer than two slots are free.
// Synchronous reset idles the parser and empties the queue.
// Depends on jsu_pkg and jsu_decode.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic       start_of_string,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       last_of_run
);

  jsu_pkg::mode_t   mode;
  jsu_pkg::mode_t   mode_next;
  logic [15:0]      accum;
  logic [15:0]      accum_next;
  logic [1:0]       seen;
  logic [1:0]       seen_next;
  jsu_pkg::step_t   step;

  jsu_pkg::result_t queue [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       count;
  logic [2:0]       count_next;
  logic             accept;
  logic             pop;
  logic [1:0]       push;

  jsu_decode u_decode (
    .mode            (mode),
    .accum           (accum),
    .seen            (seen),
    .start_of_string (start_of_string),
    .data_byte       (data_byte),
    .end_of_text     (end_of_text),
    .mode_next       (mode_next),
    .accum_next      (accum_next),
    .seen_next       (seen_next),
    .step            (step)
  );

  assign data_stall   = (count > 3'd2);
  assign accept       = data_valid && !data_stall;
  assign result_valid = (count != 3'd0);
  assign pop          = result_valid && !result_stall;
  assign push         = accept ? step.count : 2'd0;
  assign count_next   = count + {1'b0, push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= jsu_pkg::MODE_IDLE;
      accum  <= 16'd0;
      seen   <= 2'd0;
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (accept) begin
        mode  <= mode_next;
        accum <= accum_next;
        seen  <= seen_next;
      end
      wr_ptr <= wr_ptr + push;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push != 2'd0) begin
      queue[wr_ptr] <= step.first;
    end
    if (push == 2'd2) begin
      queue[wr_ptr + 2'd1] <= step.second;
    end
  end

  assign out_byte    = queue[rd_ptr].data;
  assign out_kind    = queue[rd_ptr].kind;
  assign last_of_run = queue[rd_ptr].last;

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    accept |-> ({1'b0, count} + {2'b00, step.count} <= 4'd4))
    else $error("result queue overflow");

  a_seen_in_hex : assert property (@(posedge clk) disable iff (rst)
    (seen != 2'd0) |-> (mode == jsu_pkg::MODE_HEX))
    else $error("hex digit count outside a unicode escape");

  a_done_is_last : assert property (@(posedge clk) disable iff (rst)
    (result_valid && (out_kind == jsu_pkg::KIND_DONE)) |-> last_of_run)
    else $error("done result not marked last");

  a_count_step : assert property (@(posedge clk) disable iff (rst)
    !accept |=> (count <= $past(count)))
    else $error("queue grew without an accepted beat");

endmodule

[rtl/core/jsu_decode.sv]
// Per-byte decision logic: next parser state and the results for one beat.
// Purely combinational; depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::mode_t   mode,
  input  logic [15:0]      accum,
  input  logic [1:0]       seen,
  input  logic             start_of_string,
  input  logic [7:0]       data_byte,
  input  logic             end_of_text,
  output jsu_pkg::mode_t   mode_next,
  output logic [15:0]      accum_next,
  output logic [1:0]       seen_next,
  output jsu_pkg::step_t   step
);

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  logic [4:0]      hex;
  logic [15:0]     shifted;
  logic            prim_valid;
  jsu_pkg::kind_t  prim_kind;
  logic [7:0]      prim_data;
  jsu_pkg::mode_t  mode_mid;
  logic [1:0]      seen_mid;
  logic            trail_error;

  assign hex     = hex_digit(data_byte);
  assign shifted = {accum[11:0], hex[3:0]};

  always_comb begin
    mode_mid   = mode;
    accum_next = accum;
    seen_mid   = seen;
    prim_valid = 1'b0;
    prim_kind  = jsu_pkg::KIND_CHAR;
    prim_data  = 8'd0;
    if (start_of_string) begin
      accum_next = 16'd0;
      seen_mid   = 2'd0;
      if (data_byte == jsu_pkg::CH_QUOTE) begin
        mode_mid = jsu_pkg::MODE_BODY;
      end else begin
        mode_mid   = jsu_pkg::MODE_IDLE;
        prim_valid = 1'b1;
        prim_kind  = jsu_pkg::KIND_ERROR;
      end
    end else begin
      unique case (mode)
        jsu_pkg::MODE_BODY: begin
          if (data_byte == jsu_pkg::CH_QUOTE) begin
            mode_mid   = jsu_pkg::MODE_IDLE;
            prim_valid = 1'b1;
            prim_kind  = jsu_pkg::KIND_DONE;
          end else if (data_byte == jsu_pkg::CH_BACKSLASH) begin
            mode_mid = jsu_pkg::MODE_ESC;
          end else begin
            prim_valid = 1'b1;
            prim_data  = data_byte;
          end
        end
        jsu_pkg::MODE_ESC: begin
          mode_mid   = jsu_pkg::MODE_BODY;
          prim_valid = 1'b1;
          unique case (data_byte) inside
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BACKSLASH, jsu_pkg::CH_SLASH:
              prim_data = data_byte;
            jsu_pkg::CH_B: prim_data = jsu_pkg::CODE_BS;
            jsu_pkg::CH_F: prim_data = jsu_pkg::CODE_FF;
            jsu_pkg::CH_N: prim_data = jsu_pkg::CODE_LF;
            jsu_pkg::CH_R: prim_data = jsu_pkg::CODE_CR;
            jsu_pkg::CH_T: prim_data = jsu_pkg::CODE_TAB;
            jsu_pkg::CH_U: begin
              prim_valid = 1'b0;
              mode_mid   = jsu_pkg::MODE_HEX;
              accum_next = 16'd0;
              seen_mid   = 2'd0;
            end
            default: begin
              mode_mid  = jsu_pkg::MODE_IDLE;
              prim_kind = jsu_pkg::KIND_ERROR;
            end
          endcase
        end
        jsu_pkg::MODE_HEX: begin
          if (!hex[4]) begin
            mode_mid   = jsu_pkg::MODE_IDLE;
            prim_valid = 1'b1;
            prim_kind  = jsu_pkg::KIND_ERROR;
          end else begin
            accum_next = shifted;
            if (seen == 2'd3) begin
              seen_mid   = 2'd0;
              mode_mid   = jsu_pkg::MODE_BODY;
              prim_valid = 1'b1;
              prim_data  = (shifted <= jsu_pkg::ASCII_MAX) ? shifted[7:0]
                                                           : jsu_pkg::CH_QMARK;
            end else begin
              seen_mid = seen + 2'd1;
            end
          end
        end
        default: mode_mid = jsu_pkg::MODE_IDLE;
      endcase
    end
  end

  // A string still open on the last byte of the text ends in an error.
  assign trail_error = end_of_text && (mode_mid != jsu_pkg::MODE_IDLE);
  assign mode_next   = trail_error ? jsu_pkg::MODE_IDLE : mode_mid;
  // The digit count only matters inside a \u escape, which always starts it at zero.
  assign seen_next   = (mode_next == jsu_pkg::MODE_HEX) ? seen_mid : 2'd0;

  always_comb begin
    step.count = {1'b0, prim_valid} + {1'b0, trail_error};
    if (prim_valid) begin
      step.first.data = prim_data;
      step.first.kind = prim_kind;
      step.first.last = !trail_error;
    end else begin
      step.first.data = 8'd0;
      step.first.kind = jsu_pkg::KIND_ERROR;
      step.first.last = 1'b1;
    end
    step.second.data = 8'd0;
    step.second.kind = jsu_pkg::KIND_ERROR;
    step.second.last = 1'b1;
  end

endmodule
